// ===== hw/rtl/dequ_pkg.sv =====
// types and codes shared by the double-ended queue unit
// no dependencies; compile first

package dequ_pkg;

    // request codes
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // request payload
    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] push_value;
    } dequ_req_t;

    // response payload
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] popped_value;
        logic [10:0]        entry_count;
        logic               is_empty;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
    } dequ_rsp_t;

    // control sequencer states
    typedef enum logic [0:0] {
        DEQU_IDLE,
        DEQU_READ
    } dequ_state_t;

endpackage

// ===== hw/rtl/dequ_ram.sv =====
// generic simple dual-port ram: one write port, one registered read port
// no dependencies

module dequ_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/double_ended_queue_unit.sv =====
// bounded double-ended queue of signed 32-bit values on a circular buffer
// depends on dequ_pkg and dequ_ram
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------
//   req     | in        | req_valid/req_stall | dequ_req_t
//   rsp     | out       | rsp_valid/rsp_stall | dequ_rsp_t
//
// the response to a push, a query, a failed pop or a pop that empties the queue is
// registered from the request; a pop that leaves entries also passes through the READ state:
// the new front or back entry comes from the registered read port of the entry memory
// reset clears head pointer, count and control; the entry memory is not cleared
// a request is taken while the previous response is taken in the same cycle;
// req_stall is high while a response waits on rsp_stall or a read is pending

module double_ended_queue_unit #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  dequ_pkg::dequ_req_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output dequ_pkg::dequ_rsp_t rsp
);

    import dequ_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    // wrap a sum of two slot offsets back into the buffer
    function automatic logic [AW-1:0] wrap_slot(input logic [AW:0] s);
        logic [AW:0] r;
        r = (s >= DEPTH_W) ? (s - DEPTH_W) : s;
        return r[AW-1:0];
    endfunction

    dequ_state_t      state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    occ_reg, occ_next;
    logic [31:0]      front_reg, front_next;
    logic [31:0]      back_reg, back_next;
    logic             rd_front_reg, rd_front_next;
    logic             rsp_valid_reg, rsp_valid_next;
    dequ_rsp_t        rsp_reg, rsp_next;

    logic             accept;
    logic             need_read;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [31:0]      rd_data;
    logic [CW-1:0]    occ_calc;
    logic [AW-1:0]    head_calc;
    logic [31:0]      front_calc;
    logic [31:0]      back_calc;
    logic [1:0]       status_calc;
    logic [31:0]      popped_calc;
    logic [31:0]      count_wide;
    logic             full;
    logic             empty;
    dequ_rsp_t        rsp_calc;

    // entry memory
    dequ_ram #(
        .WIDTH(32),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(req.push_value),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DEQU_IDLE:
            begin
                if (accept && need_read)
                begin
                    state_next = DEQU_READ;
                end
            end
            DEQU_READ:
            begin
                state_next = DEQU_IDLE;
            end
            default:
            begin
                state_next = DEQU_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req_stall = 1'b1;
        case (state_reg)
            DEQU_IDLE:
            begin
                req_stall = rsp_valid_reg && rsp_stall;
            end
            DEQU_READ:
            begin
                req_stall = 1'b1;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign accept = req_valid && !req_stall;
    assign full   = (occ_reg == FULL_COUNT);
    assign empty  = (occ_reg == '0);

    // request decode: pointer update, memory write and read address
    always_comb
    begin
        head_calc   = head_reg;
        occ_calc    = occ_reg;
        front_calc  = front_reg;
        back_calc   = back_reg;
        status_calc = ST_OK;
        popped_calc = '0;
        wr_en       = 1'b0;
        wr_addr     = head_reg;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        need_read   = 1'b0;
        rd_front_next = rd_front_reg;
        case (req.req_type)
            REQ_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_calc = ST_FULL;
                end
                else
                begin
                    head_calc  = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;
                    wr_en      = accept;
                    wr_addr    = head_calc;
                    occ_calc   = occ_reg + 1'b1;
                    front_calc = req.push_value;
                    if (empty)
                    begin
                        back_calc = req.push_value;
                    end
                end
            end
            REQ_PUSH_BACK:
            begin
                if (full)
                begin
                    status_calc = ST_FULL;
                end
                else
                begin
                    wr_en     = accept;
                    wr_addr   = wrap_slot({1'b0, head_reg} + {1'b0, occ_reg[AW-1:0]});
                    occ_calc  = occ_reg + 1'b1;
                    back_calc = req.push_value;
                    if (empty)
                    begin
                        front_calc = req.push_value;
                    end
                end
            end
            REQ_POP_FRONT:
            begin
                if (empty)
                begin
                    status_calc = ST_EMPTY;
                end
                else
                begin
                    popped_calc = front_reg;
                    head_calc   = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                    occ_calc    = occ_reg - 1'b1;
                    if (occ_calc != '0)
                    begin
                        // new front comes from memory
                        need_read     = 1'b1;
                        rd_en         = accept;
                        rd_addr       = head_calc;
                        rd_front_next = accept ? 1'b1 : rd_front_reg;
                    end
                end
            end
            REQ_POP_BACK:
            begin
                if (empty)
                begin
                    status_calc = ST_EMPTY;
                end
                else
                begin
                    popped_calc = back_reg;
                    occ_calc    = occ_reg - 1'b1;
                    if (occ_calc != '0)
                    begin
                        // new back sits one slot before the old back
                        need_read     = 1'b1;
                        rd_en         = accept;
                        rd_addr       = wrap_slot({1'b0, head_reg}
                                                  + {1'b0, occ_calc[AW-1:0]} - 1'b1);
                        rd_front_next = accept ? 1'b0 : rd_front_reg;
                    end
                end
            end
            default:
            begin
                status_calc = ST_OK;
            end
        endcase
    end

    // response built at request transfer
    always_comb
    begin
        count_wide            = 32'(occ_calc);
        rsp_calc.status       = status_calc;
        rsp_calc.popped_value = popped_calc;
        rsp_calc.entry_count  = count_wide[10:0];
        rsp_calc.is_empty     = (occ_calc == '0);
        rsp_calc.front_value  = (occ_calc == '0) ? '0 : front_calc;
        rsp_calc.back_value   = (occ_calc == '0) ? '0 : back_calc;
    end

    // state and response register next values
    always_comb
    begin
        head_next      = head_reg;
        occ_next       = occ_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (state_reg == DEQU_READ)
        begin
            // patch in the entry read from memory
            rsp_valid_next = 1'b1;
            if (rd_front_reg)
            begin
                front_next           = rd_data;
                rsp_next.front_value = rd_data;
            end
            else
            begin
                back_next           = rd_data;
                rsp_next.back_value = rd_data;
            end
        end
        else if (accept)
        begin
            head_next      = head_calc;
            occ_next       = occ_calc;
            front_next     = front_calc;
            back_next      = back_calc;
            rsp_next       = rsp_calc;
            rsp_valid_next = !need_read;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= DEQU_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // cached end values and response payload
    always_ff @(posedge clk)
    begin
        front_reg    <= front_next;
        back_reg     <= back_next;
        rd_front_reg <= rd_front_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hw/rtl/dequ_checker.sv =====
// port-level checks for the double-ended queue unit, bound to the top level
// depends on dequ_pkg and double_ended_queue_unit

module dequ_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input dequ_pkg::dequ_req_t req,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input dequ_pkg::dequ_rsp_t rsp
);

    import dequ_pkg::*;

    // a stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // no request transfer while a response is held back
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> req_stall)
        else $error("request taken while response stalled");

    // an empty queue reports zero count and zero end values
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_empty |->
            rsp.entry_count == '0 && rsp.front_value == '0 && rsp.back_value == '0)
        else $error("empty queue reports entries");

    // pop on empty returns nothing and leaves the queue empty
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.popped_value == '0 && rsp.is_empty)
        else $error("failed pop inconsistent");

    // a dropped push implies a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> !rsp.is_empty && rsp.popped_value == '0)
        else $error("dropped push inconsistent");

endmodule

bind double_ended_queue_unit dequ_checker u_dequ_checker (.*);
